### rtl/core/mp2d_pkg.sv
// Shared types and constants for the mean pooling block.
package mp2d_pkg;

  // Configuration port geometry and field widths.
  localparam int REG_ADDR_BITS = 4;
  localparam int DIM_BITS      = 9;
  localparam int WIN_BITS      = 4;
  localparam int DIVISOR_BITS  = 2 * WIN_BITS;

  // Register indexes, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_WINDOW_SIZE  = 2'd2,
    REG_STEP_SIZE    = 2'd3
  } reg_idx_t;

  // Register values after reset.
  localparam logic [DIM_BITS-1:0] RST_IMAGE_WIDTH  = 9'd256;
  localparam logic [DIM_BITS-1:0] RST_IMAGE_HEIGHT = 9'd256;
  localparam logic [WIN_BITS-1:0] RST_WINDOW_SIZE  = 4'd2;
  localparam logic [WIN_BITS-1:0] RST_STEP_SIZE    = 4'd2;

  // Configuration as used by the datapath, already clamped into range.
  typedef struct packed {
    logic [DIM_BITS-1:0] width;
    logic [DIM_BITS-1:0] height;
    logic [WIN_BITS-1:0] win;
    logic [WIN_BITS-1:0] step;
  } mp2d_cfg_t;

  // Request to the shared divider.
  typedef struct packed {
    logic start;
    logic wide;
  } div_req_t;

endpackage

### rtl/core/mean_pool_2d.sv
// Top level of the mean pooling block: sequencer, window summation and result register.
//
// Pixels enter on the in_ channel in raster order, one transfer each, as signed
// Q8.8 values. When a pixel is the bottom-right corner of a window whose origin
// lies on the step grid, one result leaves on the out_ channel: the window mean
// truncated toward zero, its row and column in the output grid, and a flag on
// the last window of the image. Other pixels give no result.
// The registers on the APB-style port are to be written between images by the user;
// the block itself does not enforce it. A pixel that cannot close a window
// is taken without leaving the idle state. Each check of the origin against
// the step grid is one division; an origin row off the grid ends after the
// first, a column after the second. A window corner then adds two more such
// divisions, line-store reads of all ws*ws window entries (one read port), a
// mean division and the load of the result. No pixel is taken until the
// sequencer is idle again. All divisions share one bit-serial divider.
// The result sits in an output register; the next pixel is taken while it
// waits, and the sequencer holds a second result until the first transfer.
// After reset the position is the first pixel of an image and the registers
// hold their reset values; the line store is not cleared.
module mean_pool_2d #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_WINDOW = 8,
  parameter int PIXEL_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [PIXEL_BITS-1:0]              in_pixel_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [PIXEL_BITS-1:0]              out_mean_value,
  output logic [7:0]                         out_window_row,
  output logic [7:0]                         out_window_col,
  output logic                               out_last_window,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mp2d_pkg::REG_ADDR_BITS-1:0] paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import mp2d_pkg::*;

  localparam int CW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int SW      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LOG_WIN = $clog2(MAX_WINDOW);
  localparam int SUMW    = PIXEL_BITS + 2 * LOG_WIN + 1;
  localparam int DW      = (SUMW > CW) ? SUMW : CW;
  localparam int PW      = (CW + 1 > 10) ? CW + 1 : 10;
  localparam int TW      = ((SW > WIN_BITS) ? SW : WIN_BITS) + 1;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DIV_TOP  = 8'b0000_0010,
    S_DIV_LEFT = 8'b0000_0100,
    S_DIV_OH   = 8'b0000_1000,
    S_DIV_OW   = 8'b0001_0000,
    S_SUM      = 8'b0010_0000,
    S_DIV_MEAN = 8'b0100_0000,
    S_OUT      = 8'b1000_0000
  } state_t;

  mp2d_cfg_t cfg;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         row_r, row_nxt;
  logic [CW-1:0]         col_r, col_nxt;
  logic [SW-1:0]         slot_r, slot_nxt;
  logic [CW-1:0]         top_r, left_r;
  logic [SW-1:0]         tslot_r;
  logic [CW-1:0]         wr_idx_r, wc_idx_r, oh_r, ow_r;
  logic [WIN_BITS-1:0]   i_r, j_r;
  logic [SW-1:0]         rslot_r;
  logic                  issued_all_r;
  logic                  pend_r;
  logic signed [SUMW-1:0] sum_r;
  logic [PIXEL_BITS-1:0] mean_r;
  logic                  div_start_r, div_start_nxt;
  logic                  out_valid_r;
  logic [PIXEL_BITS-1:0] out_mean_r;
  logic [7:0]            out_row_r, out_col_r;
  logic                  out_last_r;

  logic                  in_fire, out_free, in_image, cand, issue;
  logic [PW-1:0]         r_ext, c_ext, h_ext, w_ext, ws_ext, top_v, left_v, oh_v, ow_v;
  logic [WIN_BITS-1:0]   ws_m1;
  logic [TW-1:0]         slot_ext, wsm1_ext, tslot_v;
  logic [SW-1:0]         slot_inc, rslot_inc;
  logic [SUMW-1:0]       sum_abs;
  logic [PIXEL_BITS-1:0] mean_mag;
  logic [PIXEL_BITS-1:0] rd_data;
  logic [CW-1:0]         rd_col;

  div_req_t                  div_req;
  logic [DW-1:0]             div_dividend, div_quo;
  logic [DIVISOR_BITS-1:0]   div_divisor, div_rem;
  logic                      div_done;

  // Configuration registers.
  mp2d_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake terms.
  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid & in_ready;
  assign out_free = ~out_valid_r | out_ready;

  // Position checks for the pixel being offered.
  always_comb begin
    r_ext    = PW'(row_r);
    c_ext    = PW'(col_r);
    h_ext    = PW'(cfg.height);
    w_ext    = PW'(cfg.width);
    ws_ext   = PW'(cfg.win);
    ws_m1    = cfg.win - 4'd1;
    in_image = (r_ext < h_ext) && (c_ext < w_ext);
    cand     = in_image && (r_ext + 1'b1 >= ws_ext) && (c_ext + 1'b1 >= ws_ext);
    top_v    = r_ext + 1'b1 - ws_ext;
    left_v   = c_ext + 1'b1 - ws_ext;
    oh_v     = h_ext - ws_ext;
    ow_v     = w_ext - ws_ext;
    slot_ext = TW'(slot_r);
    wsm1_ext = TW'(ws_m1);
    tslot_v  = (slot_ext >= wsm1_ext) ? (slot_ext - wsm1_ext)
                                      : (slot_ext + TW'(MAX_WINDOW) - wsm1_ext);
    slot_inc = (slot_r == SW'(MAX_WINDOW - 1)) ? '0 : slot_r + 1'b1;
    rslot_inc = (rslot_r == SW'(MAX_WINDOW - 1)) ? '0 : rslot_r + 1'b1;
  end

  // Raster position of the next pixel, with row slot = row mod MAX_WINDOW.
  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r;
    slot_nxt = slot_r;
    if (c_ext + 1'b1 >= w_ext) begin
      col_nxt = '0;
      if (r_ext + 1'b1 >= h_ext) begin
        row_nxt  = '0;
        slot_nxt = '0;
      end else begin
        row_nxt  = row_r + 1'b1;
        slot_nxt = slot_inc;
      end
    end else begin
      col_nxt = col_r + 1'b1;
      if (r_ext >= h_ext) begin
        row_nxt  = '0;
        slot_nxt = '0;
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (in_fire && cand) state_nxt = S_DIV_TOP;
      S_DIV_TOP:  if (div_done) state_nxt = (div_rem != '0) ? S_IDLE : S_DIV_LEFT;
      S_DIV_LEFT: if (div_done) state_nxt = (div_rem != '0) ? S_IDLE : S_DIV_OH;
      S_DIV_OH:   if (div_done) state_nxt = S_DIV_OW;
      S_DIV_OW:   if (div_done) state_nxt = S_SUM;
      S_SUM:      if (issued_all_r && !pend_r) state_nxt = S_DIV_MEAN;
      S_DIV_MEAN: if (div_done) state_nxt = S_OUT;
      S_OUT:      if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
    div_start_nxt = (state_nxt != state_r) &&
                    ((state_nxt == S_DIV_TOP) || (state_nxt == S_DIV_LEFT) ||
                     (state_nxt == S_DIV_OH) || (state_nxt == S_DIV_OW) ||
                     (state_nxt == S_DIV_MEAN));
  end

  // Divider operands follow the current step.
  always_comb begin
    sum_abs     = sum_r[SUMW-1] ? $unsigned(-sum_r) : $unsigned(sum_r);
    div_divisor = {4'd0, cfg.step};
    case (state_r)
      S_DIV_TOP:  div_dividend = DW'(top_r);
      S_DIV_LEFT: div_dividend = DW'(left_r);
      S_DIV_OH:   div_dividend = DW'(oh_v[CW-1:0]);
      S_DIV_OW:   div_dividend = DW'(ow_v[CW-1:0]);
      S_DIV_MEAN: begin
        div_dividend = DW'(sum_abs);
        div_divisor  = cfg.win * cfg.win;
      end
      default:    div_dividend = '0;
    endcase
    div_req.start = div_start_r;
    div_req.wide  = (state_r == S_DIV_MEAN);
  end

  mp2d_div #(
    .DW (DW),
    .NW (CW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (div_req),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Window reads, one line-store entry per cycle.
  assign issue  = (state_r == S_SUM) && !issued_all_r;
  assign rd_col = left_r + CW'(j_r);

  mp2d_line_store #(
    .ROWS   (MAX_WINDOW),
    .COLS   (MAX_WIDTH),
    .DATA_W (PIXEL_BITS),
    .SW     (SW),
    .CW     (CW)
  ) u_store (
    .clk     (clk),
    .wr_en   (in_fire && in_image),
    .wr_slot (slot_r),
    .wr_col  (col_r),
    .wr_data (in_pixel_value),
    .rd_en   (issue),
    .rd_slot (rslot_r),
    .rd_col  (rd_col),
    .rd_data (rd_data)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      row_r        <= '0;
      col_r        <= '0;
      slot_r       <= '0;
      div_start_r  <= 1'b0;
      issued_all_r <= 1'b0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_start_r <= div_start_nxt;
      pend_r      <= issue;
      if (in_fire) begin
        row_r  <= row_nxt;
        col_r  <= col_nxt;
        slot_r <= slot_nxt;
      end
      if (state_r == S_DIV_OW && div_done) begin
        issued_all_r <= 1'b0;
      end else if (issue && i_r == ws_m1 && j_r == ws_m1) begin
        issued_all_r <= 1'b1;
      end
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign mean_mag = div_quo[PIXEL_BITS-1:0];

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      top_r   <= top_v[CW-1:0];
      left_r  <= left_v[CW-1:0];
      tslot_r <= tslot_v[SW-1:0];
    end
    if (div_done) begin
      case (state_r)
        S_DIV_TOP:  wr_idx_r <= div_quo[CW-1:0];
        S_DIV_LEFT: wc_idx_r <= div_quo[CW-1:0];
        S_DIV_OH:   oh_r     <= div_quo[CW-1:0];
        S_DIV_OW:   ow_r     <= div_quo[CW-1:0];
        S_DIV_MEAN: mean_r   <= sum_r[SUMW-1] ? (~mean_mag + 1'b1) : mean_mag;
        default: ;
      endcase
    end
    // Start of the window sum.
    if (state_r == S_DIV_OW && div_done) begin
      i_r     <= '0;
      j_r     <= '0;
      rslot_r <= tslot_r;
      sum_r   <= '0;
    end else begin
      if (issue) begin
        if (j_r == ws_m1) begin
          j_r     <= '0;
          i_r     <= i_r + 1'b1;
          rslot_r <= rslot_inc;
        end else begin
          j_r <= j_r + 1'b1;
        end
      end
      if (pend_r) begin
        sum_r <= sum_r + SUMW'(signed'(rd_data));
      end
    end
    // Result register, loaded once the previous result has left.
    if (state_r == S_OUT && out_free) begin
      out_mean_r <= mean_r;
      out_row_r  <= 8'(wr_idx_r);
      out_col_r  <= 8'(wc_idx_r);
      out_last_r <= (wr_idx_r == oh_r) && (wc_idx_r == ow_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_mean_value  = out_mean_r;
  assign out_window_row  = out_row_r;
  assign out_window_col  = out_col_r;
  assign out_last_window = out_last_r;

endmodule

### rtl/core/mp2d_line_store.sv
// Line store memory: one write port and one registered read port.
module mp2d_line_store #(
  parameter int ROWS   = 8,
  parameter int COLS   = 256,
  parameter int DATA_W = 16,
  parameter int SW     = 3,
  parameter int CW     = 8
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [SW-1:0]     wr_slot,
  input  logic [CW-1:0]     wr_col,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [SW-1:0]     rd_slot,
  input  logic [CW-1:0]     rd_col,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [ROWS][COLS];

  // Write the incoming pixel into its row slot.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_slot][wr_col] <= wr_data;
    end
  end

  // Registered read for the window sum.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_slot][rd_col];
    end
  end

endmodule

### rtl/core/mp2d_div.sv
// Shared restoring divider, one quotient bit per cycle, narrow or wide mode.
module mp2d_div #(
  parameter int DW = 23,
  parameter int NW = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mp2d_pkg::div_req_t                  req,
  input  logic [DW-1:0]                       dividend,
  input  logic [mp2d_pkg::DIVISOR_BITS-1:0]   divisor,
  output logic                                done,
  output logic [DW-1:0]                       quotient,
  output logic [mp2d_pkg::DIVISOR_BITS-1:0]   remainder
);
  import mp2d_pkg::*;

  localparam int CNTW = $clog2(DW + 1);
  localparam int VW   = DIVISOR_BITS;

  logic [DW-1:0]   q_r;
  logic [VW-1:0]   rem_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [VW:0]     rem_sh;
  logic [VW+1:0]   trial;

  // One trial subtraction per step.
  assign rem_sh = {rem_r, q_r[DW-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, divisor};

  // Control: step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= req.wide ? CNTW'(DW) : CNTW'(NW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNTW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // Datapath: a narrow dividend is aligned to the top of the shift register.
  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r   <= req.wide ? dividend : (dividend << (DW - NW));
      rem_r <= '0;
    end else if (busy_r) begin
      if (!trial[VW+1]) begin
        rem_r <= trial[VW-1:0];
        q_r   <= {q_r[DW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[VW-1:0];
        q_r   <= {q_r[DW-2:0], 1'b0};
      end
    end
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

### rtl/core/mp2d_cfg.sv
// Configuration registers behind the APB-style port, with range clamping.
module mp2d_cfg #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_WINDOW = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mp2d_pkg::REG_ADDR_BITS-1:0] paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  output mp2d_pkg::mp2d_cfg_t                cfg
);
  import mp2d_pkg::*;

  localparam logic [DIM_BITS-1:0] DIM_CAP =
    (MAX_WIDTH > 511) ? 9'd511 : DIM_BITS'(MAX_WIDTH);
  localparam logic [WIN_BITS-1:0] WIN_CAP =
    (MAX_WINDOW > 15) ? 4'd15 : WIN_BITS'(MAX_WINDOW);

  logic [DIM_BITS-1:0] width_r;
  logic [DIM_BITS-1:0] height_r;
  logic [WIN_BITS-1:0] win_r;
  logic [WIN_BITS-1:0] step_r;
  logic                wr_en;
  reg_idx_t            idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);

  // Register writes on the access cycle of a write transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_IMAGE_WIDTH;
      height_r <= RST_IMAGE_HEIGHT;
      win_r    <= RST_WINDOW_SIZE;
      step_r   <= RST_STEP_SIZE;
    end else if (wr_en) begin
      case (idx)
        REG_IMAGE_WIDTH:  width_r  <= pwdata[DIM_BITS-1:0];
        REG_IMAGE_HEIGHT: height_r <= pwdata[DIM_BITS-1:0];
        REG_WINDOW_SIZE:  win_r    <= pwdata[WIN_BITS-1:0];
        REG_STEP_SIZE:    step_r   <= pwdata[WIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read back the stored values.
  always_comb begin
    case (idx)
      REG_IMAGE_WIDTH:  prdata = {23'd0, width_r};
      REG_IMAGE_HEIGHT: prdata = {23'd0, height_r};
      REG_WINDOW_SIZE:  prdata = {28'd0, win_r};
      REG_STEP_SIZE:    prdata = {28'd0, step_r};
      default:          prdata = 32'd0;
    endcase
  end

  // Zero acts as one, and values above the supported maximum saturate.
  always_comb begin
    cfg.width  = (width_r == '0) ? 9'd1 : ((width_r > DIM_CAP) ? DIM_CAP : width_r);
    cfg.height = (height_r == '0) ? 9'd1 : ((height_r > DIM_CAP) ? DIM_CAP : height_r);
    cfg.win    = (win_r == '0) ? 4'd1 : ((win_r > WIN_CAP) ? WIN_CAP : win_r);
    cfg.step   = (step_r == '0) ? 4'd1 : ((step_r > WIN_CAP) ? WIN_CAP : step_r);
  end

endmodule

### dv/mp2d_checker.sv
// Scoreboard for the mean pooling block: predicts every window mean and checks each result transfer.
module mp2d_checker #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_WINDOW = 8,
  parameter int PIXEL_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [PIXEL_BITS-1:0]              in_pixel_value,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [PIXEL_BITS-1:0]              out_mean_value,
  input  logic [7:0]                         out_window_row,
  input  logic [7:0]                         out_window_col,
  input  logic                               out_last_window,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mp2d_pkg::REG_ADDR_BITS-1:0] paddr,
  input  logic [31:0]                        pwdata,
  input  logic                               pready,
  output int                                 fail_count,
  output int                                 open_results
);
  import mp2d_pkg::*;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] mean_value;
    logic [7:0]            window_row;
    logic [7:0]            window_col;
    logic                  last_window;
  } window_mean_t;

  // Shadow copy of the registers as written on the configuration port.
  logic [DIM_BITS-1:0] image_width;
  logic [DIM_BITS-1:0] image_height;
  logic [WIN_BITS-1:0] window_size;
  logic [WIN_BITS-1:0] step_size;

  // Shadow line store and raster position of the next pixel.
  logic [PIXEL_BITS-1:0] line_store [MAX_WINDOW*MAX_WIDTH];
  int unsigned           next_row;
  int unsigned           next_col;

  // Window means predicted but not yet seen on the result channel.
  window_mean_t expected_means[$];

  // Out-of-range register values act as the nearest meaningful value.
  function automatic int unsigned saturate(input int unsigned value, input int unsigned ceiling);
    if (value == 0) return 1;
    if (value > ceiling) return ceiling;
    return value;
  endfunction

  function automatic int unsigned store_slot(input int unsigned row, input int unsigned col);
    return (row % MAX_WINDOW) * MAX_WIDTH + (col % MAX_WIDTH);
  endfunction

  task automatic apply_write(input reg_idx_t idx, input logic [31:0] data);
    case (idx)
      REG_IMAGE_WIDTH:  image_width  = data[DIM_BITS-1:0];
      REG_IMAGE_HEIGHT: image_height = data[DIM_BITS-1:0];
      REG_WINDOW_SIZE:  window_size  = data[WIN_BITS-1:0];
      REG_STEP_SIZE:    step_size    = data[WIN_BITS-1:0];
      default: ;
    endcase
  endtask

  // Store the pixel, and when it closes a window on the step grid, queue that window's mean.
  task automatic absorb_pixel(input logic [PIXEL_BITS-1:0] pixel);
    int unsigned  w;
    int unsigned  h;
    int unsigned  ws;
    int unsigned  st;
    int unsigned  r;
    int unsigned  c;
    int unsigned  top;
    int unsigned  left;
    longint       acc;
    window_mean_t mean;
    w  = saturate(image_width, MAX_WIDTH);
    h  = saturate(image_height, MAX_WIDTH);
    ws = saturate(window_size, MAX_WINDOW);
    st = saturate(step_size, MAX_WINDOW);
    r  = next_row;
    c  = next_col;
    if (r < h && c < w) begin
      line_store[store_slot(r, c)] = pixel;
      if (r + 1 >= ws && c + 1 >= ws) begin
        top  = r + 1 - ws;
        left = c + 1 - ws;
        if (top % st == 0 && left % st == 0) begin
          acc = 0;
          for (int i = 0; i < ws; i++) begin
            for (int j = 0; j < ws; j++) begin
              acc += longint'($signed(line_store[store_slot(top + i, left + j)]));
            end
          end
          // Signed division truncates toward zero, as the block does.
          mean.mean_value  = PIXEL_BITS'(acc / longint'(ws * ws));
          mean.window_row  = 8'(top / st);
          mean.window_col  = 8'(left / st);
          mean.last_window = (top / st == (h - ws) / st) && (left / st == (w - ws) / st);
          expected_means.push_back(mean);
        end
      end
    end
    // Advance the raster position, wrapping at the row and at the image end.
    if (c + 1 >= w) begin
      next_col = 0;
      next_row = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      next_col = c + 1;
      if (r >= h) next_row = 0;
    end
  endtask

  task automatic check_result();
    window_mean_t want;
    if (expected_means.size() == 0) begin
      $error("result transfer with no window pending: mean_value %0d row %0d col %0d",
             $signed(out_mean_value), out_window_row, out_window_col);
      fail_count++;
    end else begin
      want = expected_means.pop_front();
      if (out_mean_value !== want.mean_value) begin
        $error("mean_value: expected %0d, got %0d",
               $signed(want.mean_value), $signed(out_mean_value));
        fail_count++;
      end
      if (out_window_row !== want.window_row) begin
        $error("window_row: expected %0d, got %0d", want.window_row, out_window_row);
        fail_count++;
      end
      if (out_window_col !== want.window_col) begin
        $error("window_col: expected %0d, got %0d", want.window_col, out_window_col);
        fail_count++;
      end
      if (out_last_window !== want.last_window) begin
        $error("last_window: expected %0d, got %0d", want.last_window, out_last_window);
        fail_count++;
      end
    end
  endtask

  // Watch the three ports at every rising edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      image_width  = RST_IMAGE_WIDTH;
      image_height = RST_IMAGE_HEIGHT;
      window_size  = RST_WINDOW_SIZE;
      step_size    = RST_STEP_SIZE;
      next_row     = 0;
      next_col     = 0;
      expected_means.delete();
      fail_count   = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        apply_write(reg_idx_t'(paddr[REG_ADDR_BITS-1:2]), pwdata);
      end
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) absorb_pixel(in_pixel_value);
    end
    open_results = expected_means.size();
  end

endmodule

### dv/testbench.sv
// Top of the mean pooling testbench: clock, reset, pixel and register stimulus, and the verdict.
module testbench;
  import mp2d_pkg::*;

  localparam int DRAIN_CYCLES  = 300;
  localparam int HOLD_CYCLES   = 1500;
  localparam int STALL_LIMIT   = 20000;
  localparam int RANDOM_PIXELS = 100;

  typedef enum {FILL_RANDOM, FILL_EXTREME, FILL_SMALL} fill_kind_t;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [15:0]              in_pixel_value;
  logic                     out_valid;
  logic                     out_ready;
  logic [15:0]              out_mean_value;
  logic [7:0]               out_window_row;
  logic [7:0]               out_window_col;
  logic                     out_last_window;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [REG_ADDR_BITS-1:0] paddr;
  logic [31:0]              pwdata;
  logic [31:0]              prdata;
  logic                     pready;

  int fail_count;
  int open_results;
  int stall_cycles;
  bit steady;
  bit park_sink;

  always #5 clk = ~clk;

  mean_pool_2d i_dut (.*);

  mp2d_checker i_checker (.*);

  // Watchdog: ends the run when no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("mean_pool_2d: mismatch");
      $finish;
    end
  end

  // Result side: random stalls per transfer, plus one long hold-off when asked.
  initial begin : result_sink
    bit parked;
    int gap;
    parked = 1'b0;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 5);
      if (park_sink && !parked) begin
        gap = HOLD_CYCLES;
        parked = 1'b1;
      end
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic int unsigned clamp_dim(input logic [8:0] value);
    if (value == 0) return 1;
    return (value > 256) ? 256 : value;
  endfunction

  // Offer one pixel after a random gap and hold it until the transfer.
  task automatic send_pixel(input logic [15:0] value);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel_value <= value;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_image(input int unsigned count, input fill_kind_t fill);
    logic [15:0] value;
    for (int k = 0; k < count; k++) begin
      case (fill)
        FILL_EXTREME: value = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        FILL_SMALL:   value = 16'($urandom_range(0, 8) - 4);
        default:      value = 16'($urandom);
      endcase
      send_pixel(value);
    end
  endtask

  // Drop valid, wait until every predicted window has arrived, then let the block go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (open_results != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write: setup cycle, then access cycle until pready.
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic setup(input logic [8:0] width, input logic [8:0] height,
                       input logic [3:0] win, input logic [3:0] step);
    settle();
    write_reg(REG_IMAGE_WIDTH, 32'(width));
    write_reg(REG_IMAGE_HEIGHT, 32'(height));
    write_reg(REG_WINDOW_SIZE, 32'(win));
    write_reg(REG_STEP_SIZE, 32'(step));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin : stimulus
    logic [8:0]  width;
    logic [8:0]  height;
    logic [3:0]  win;
    logic [3:0]  step;
    int unsigned count;
    int          random_sent;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_pixel_value <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    steady    = 1'b0;
    park_sink = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Overlapping 2x2 windows on saturated pixels, with sums that truncate toward zero.
    setup(9'd3, 9'd3, 4'd2, 4'd1);
    send_pixel(16'h7FFF);
    send_pixel(16'h7FFF);
    send_pixel(16'h8000);
    send_pixel(16'h7FFF);
    send_pixel(16'h7FFF);
    send_pixel(16'h8000);
    send_pixel(16'hFFFF);
    send_pixel(16'hFFFF);
    send_pixel(16'hFFFD);

    // A window larger than the image gives no result at all.
    setup(9'd2, 9'd2, 4'd3, 4'd1);
    send_pixel(16'h0000);
    send_pixel(16'h0001);
    send_pixel(16'hFFFF);
    send_pixel(16'h8000);

    // Zero registers act as one: every pixel is its own window.
    setup(9'd0, 9'd3, 4'd0, 4'd0);
    send_pixel(16'h8000);
    send_pixel(16'h7FFF);
    send_pixel(16'h0000);

    // A step above the maximum saturates, leaving a single window per row band.
    setup(9'd5, 9'd2, 4'd2, 4'hF);
    send_image(10, FILL_RANDOM);

    // Oversized width saturates; every column index is produced while the
    // result side holds off long enough for the input to back up.
    steady = 1'b1;
    setup(9'h1FF, 9'd1, 4'd1, 4'd1);
    park_sink = 1'b1;
    send_image(256, FILL_RANDOM);

    // Oversized height saturates; every row index is produced.
    steady = 1'b0;
    setup(9'd1, 9'h1FF, 4'd1, 4'd1);
    send_image(256, FILL_RANDOM);

    // Largest window, reached through an oversized window register.
    setup(9'd8, 9'd9, 4'hF, 4'hF);
    send_image(72, FILL_EXTREME);

    // Random geometries, mostly small images, some with out-of-range registers.
    random_sent = 0;
    while (random_sent < RANDOM_PIXELS) begin
      width  = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(17, 40))
                                           : 9'($urandom_range(0, 12));
      height = 9'($urandom_range(0, 10));
      win    = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(1, 4));
      step   = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(1, 4));
      steady = ($urandom_range(0, 3) == 0);
      setup(width, height, win, step);
      repeat ($urandom_range(1, 2)) begin
        count = clamp_dim(width) * clamp_dim(height);
        send_image(count, fill_kind_t'($urandom_range(0, 2)));
        random_sent += count;
      end
    end

    settle();
    @(negedge clk);
    if (fail_count == 0 && open_results == 0) begin
      $display("mean_pool_2d: match");
    end else begin
      $display("mean_pool_2d: mismatch");
    end
    $finish;
  end

endmodule
